[sv/lbrq_pkg.sv]
// Shared types, codes and constants of the line-buffered receive queue.
package lbrq_pkg;

	localparam int BUFFER_DEPTH_DEFAULT = 128;
	localparam logic [7:0] NEWLINE = 8'h0A;

	typedef enum logic [1:0] {
		OP_RX    = 2'd0,
		OP_READ  = 2'd1,
		OP_OPEN  = 2'd2,
		OP_CLOSE = 2'd3
	} op_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic port_en;
		logic pending;
		logic len_zero;
		logic cnt_ge_len;
		logic cnt_zero;
		logic rx_room;
		logic rx_complete;
		logic scan_hit;
		logic scan_miss;
		logic emit_done;
		logic out_free;
	} sts_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic do_open;
		logic do_close;
		logic rx_write;
		logic emit_rx;
		logic emit_len;
		logic emit_hit;
		logic scan_start;
		logic scan_run;
		logic emit_run;
		logic set_pending;
		logic latch_target;
		logic load_empty;
	} cmd_t;

endpackage

[sv/lbrq_ifs.sv]
// Valid/ready channel interfaces for request and result items.
interface lbrq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  rx_byte;
	logic [15:0] read_length;

	modport source (output valid, output operation, output rx_byte, output read_length,
		input ready);
	modport sink (input valid, input operation, input rx_byte, input read_length,
		output ready);
endinterface

interface lbrq_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_data;
	logic       last;
	logic       line_end;

	modport source (output valid, output data_byte, output has_data, output last,
		output line_end, input ready);
	modport sink (input valid, input data_byte, input has_data, input last,
		input line_end, output ready);
endinterface

[sv/lbrq_ctrl.sv]
// Controller state machine: sequences open, close, receive, scan, emit and empty-result steps.
module lbrq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lbrq_pkg::sts_t sts,
	output lbrq_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EMIT = 4'b0100,
		S_ZERO = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   fire;

	assign req_ready = (state_q == S_IDLE);
	assign fire      = req_valid && req_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (fire) begin
					unique case (sts.op)
						lbrq_pkg::OP_OPEN: cmd.do_open = 1'b1;
						lbrq_pkg::OP_CLOSE: cmd.do_close = 1'b1;
						lbrq_pkg::OP_RX: begin
							if (sts.port_en && sts.rx_room) begin
								cmd.rx_write = 1'b1;
								if (sts.rx_complete) begin
									cmd.emit_rx = 1'b1;
									state_d     = S_EMIT;
								end
							end
						end
						lbrq_pkg::OP_READ: begin
							if (sts.port_en && !sts.pending) begin
								if (sts.len_zero) begin
									state_d = S_ZERO;
								end else if (sts.cnt_ge_len) begin
									cmd.emit_len = 1'b1;
									state_d      = S_EMIT;
								end else if (sts.cnt_zero) begin
									cmd.latch_target = 1'b1;
									cmd.set_pending  = 1'b1;
								end else begin
									cmd.latch_target = 1'b1;
									cmd.scan_start   = 1'b1;
									state_d          = S_SCAN;
								end
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_hit) begin
					cmd.emit_hit = 1'b1;
					state_d      = S_EMIT;
				end else if (sts.scan_miss) begin
					cmd.set_pending = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_EMIT: begin
				cmd.emit_run = 1'b1;
				if (sts.emit_done) begin
					state_d = S_IDLE;
				end
			end
			S_ZERO: begin
				if (sts.out_free) begin
					cmd.load_empty = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/lbrq_dp.sv]
// Datapath: byte ring, pointers, port flags, scan and emit counters, result register.
module lbrq_dp #(
	parameter int BUFFER_DEPTH = lbrq_pkg::BUFFER_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     operation,
	input  logic [7:0]     rx_byte,
	input  logic [15:0]    read_length,
	input  lbrq_pkg::cmd_t cmd,
	output lbrq_pkg::sts_t sts,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output logic [7:0]     data_byte,
	output logic           has_data,
	output logic           last,
	output logic           line_end
);

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(BUFFER_DEPTH - 1);
	localparam logic [PTR_W-1:0] HALF_LEN = PTR_W'(BUFFER_DEPTH / 2);
	localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(BUFFER_DEPTH);

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	logic [7:0]       mem_q [BUFFER_DEPTH];
	logic [PTR_W-1:0] rp_q, wp_q;
	logic             en_q, pending_q;
	logic [PTR_W-1:0] target_q;
	logic [PTR_W-1:0] scan_ptr_q, iss_k_q;
	logic [PTR_W-1:0] emit_left_q;
	logic             ends_q;
	logic             v_s1;
	logic [7:0]       data_s1;
	logic [PTR_W-1:0] idx_s1;
	logic             fin_s1;
	logic             out_v_q;
	logic [7:0]       out_data_q;
	logic             out_has_q, out_last_q, out_le_q;

	logic [PTR_W-1:0] cnt, cnt_inc, len_sat, emit_n, rd_addr;
	logic             rx_is_nl, out_free, scan_hit, scan_issue, emit_issue;
	logic             emit_start, emit_load, rd_en, ends_d;

	assign cnt = (wp_q >= rp_q) ? (wp_q - rp_q)
		: PTR_W'({1'b0, wp_q} + DEPTH_X - {1'b0, rp_q});
	assign cnt_inc  = cnt + 1'b1;
	assign len_sat  = (read_length > 16'(BUFFER_DEPTH / 2)) ? HALF_LEN
		: read_length[PTR_W-1:0];
	assign rx_is_nl = (rx_byte == lbrq_pkg::NEWLINE);
	assign out_free = !out_v_q || rsp_ready;
	assign scan_hit = v_s1 && (data_s1 == lbrq_pkg::NEWLINE);

	// Scan issues one read a cycle until all stored bytes are fetched or a newline shows.
	assign scan_issue = cmd.scan_run && (iss_k_q < cnt) && !scan_hit;
	assign emit_issue = cmd.emit_run && (emit_left_q != '0) && (!v_s1 || out_free);
	assign emit_load  = cmd.emit_run && v_s1 && out_free;
	assign emit_start = cmd.emit_rx || cmd.emit_len || cmd.emit_hit;
	assign rd_en      = scan_issue || emit_issue;
	assign rd_addr    = cmd.scan_run ? scan_ptr_q : rp_q;

	always_comb begin
		if (cmd.emit_rx) begin
			emit_n = cnt_inc;
			ends_d = rx_is_nl;
		end else if (cmd.emit_len) begin
			emit_n = len_sat;
			ends_d = 1'b0;
		end else begin
			emit_n = idx_s1 + 1'b1;
			ends_d = 1'b1;
		end
	end

	always_comb begin
		sts             = '0;
		sts.op          = lbrq_pkg::op_t'(operation);
		sts.port_en     = en_q;
		sts.pending     = pending_q;
		sts.len_zero    = (len_sat == '0);
		sts.cnt_ge_len  = (cnt >= len_sat);
		sts.cnt_zero    = (cnt == '0);
		sts.rx_room     = (next_ptr(wp_q) != rp_q);
		sts.rx_complete = pending_q && (rx_is_nl || (cnt_inc == target_q));
		sts.scan_hit    = scan_hit;
		sts.scan_miss   = v_s1 && !scan_hit && (PTR_W'(idx_s1 + 1'b1) == cnt);
		sts.emit_done   = (emit_left_q == '0) && !v_s1;
		sts.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			wp_q        <= '0;
			en_q        <= 1'b0;
			pending_q   <= 1'b0;
			target_q    <= '0;
			scan_ptr_q  <= '0;
			iss_k_q     <= '0;
			emit_left_q <= '0;
			ends_q      <= 1'b0;
			v_s1        <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cmd.do_open) begin
				rp_q <= '0;
				wp_q <= '0;
			end else begin
				if (emit_issue) begin
					rp_q <= next_ptr(rp_q);
				end
				if (cmd.rx_write) begin
					wp_q <= next_ptr(wp_q);
				end
			end

			if (cmd.do_open) begin
				en_q <= 1'b1;
			end else if (cmd.do_close) begin
				en_q <= 1'b0;
			end

			if (cmd.do_open || cmd.do_close || cmd.emit_rx) begin
				pending_q <= 1'b0;
			end else if (cmd.set_pending) begin
				pending_q <= 1'b1;
			end

			if (cmd.latch_target) begin
				target_q <= len_sat;
			end

			if (cmd.scan_start) begin
				scan_ptr_q <= rp_q;
				iss_k_q    <= '0;
			end else if (scan_issue) begin
				scan_ptr_q <= next_ptr(scan_ptr_q);
				iss_k_q    <= iss_k_q + 1'b1;
			end

			if (emit_start) begin
				emit_left_q <= emit_n;
				ends_q      <= ends_d;
			end else if (emit_issue) begin
				emit_left_q <= emit_left_q - 1'b1;
			end

			// Drop the fetch stage outside scan and emit; scan consumes it every cycle.
			if (cmd.scan_run) begin
				v_s1 <= scan_issue;
			end else if (cmd.emit_run) begin
				v_s1 <= emit_issue || (v_s1 && !out_free);
			end else begin
				v_s1 <= 1'b0;
			end

			if (emit_load || cmd.load_empty) begin
				out_v_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rx_write) begin
			mem_q[wp_q] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_s1 <= mem_q[rd_addr];
			idx_s1  <= iss_k_q;
			fin_s1  <= (emit_left_q == PTR_W'(1));
		end
		if (emit_load) begin
			out_data_q <= data_s1;
			out_has_q  <= 1'b1;
			out_last_q <= fin_s1;
			out_le_q   <= fin_s1 && ends_q;
		end else if (cmd.load_empty) begin
			out_data_q <= 8'h00;
			out_has_q  <= 1'b0;
			out_last_q <= 1'b1;
			out_le_q   <= 1'b0;
		end
	end

	assign rsp_valid = out_v_q;
	assign data_byte = out_data_q;
	assign has_data  = out_has_q;
	assign last      = out_last_q;
	assign line_end  = out_le_q;

endmodule

[sv/line_buffered_receive_queue.sv]
// Top level of the line-buffered receive queue: controller and datapath.
//
// Requests are taken one at a time. A read that can be served at once streams
// its bytes one per cycle while the receiver takes them, each byte passing
// through the fetch stage and the result register; a read that must look for
// a newline first scans the stored bytes one per cycle. The pace is set by
// the single read port of the byte ring. The result register lets a finished
// run's final item wait while the next request is already taken. The ring
// needs no clearing after reset: only bytes written since the last open are
// ever read.
module line_buffered_receive_queue #(
	parameter int BUFFER_DEPTH = lbrq_pkg::BUFFER_DEPTH_DEFAULT
) (
	input logic         clk,
	input logic         arst_n,
	lbrq_req_if.sink    req,
	lbrq_rsp_if.source  rsp
);

	lbrq_pkg::sts_t sts;
	lbrq_pkg::cmd_t cmd;

	lbrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lbrq_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (req.operation),
		.rx_byte     (req.rx_byte),
		.read_length (req.read_length),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.data_byte   (rsp.data_byte),
		.has_data    (rsp.has_data),
		.last        (rsp.last),
		.line_end    (rsp.line_end)
	);

endmodule

[sv/lbrq_checker.sv]
// Port-level checker for the line-buffered receive queue, bound to the top level.
module lbrq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [7:0]  data_byte,
	input logic        has_data,
	input logic        last,
	input logic        line_end
);

	// A stalled result holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_byte) && $stable(has_data)
			&& $stable(last) && $stable(line_end))
		else $error("result item changed while stalled");

	// An empty result stands alone and carries no byte.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !has_data |-> last && !line_end && (data_byte == 8'h00))
		else $error("malformed empty result");

	// A run that ends on a line ends on the newline byte itself.
	a_line_end_nl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && line_end |-> last && has_data && (data_byte == lbrq_pkg::NEWLINE))
		else $error("line_end without a final newline");

	// No result can appear in the cycle right after a request is taken.
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared too early after a request");

endmodule

bind line_buffered_receive_queue lbrq_checker u_lbrq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.data_byte (rsp.data_byte),
	.has_data  (rsp.has_data),
	.last      (rsp.last),
	.line_end  (rsp.line_end)
);
